/* rtl/scfla_pkg.sv */
// Package for the size-class free-list allocator: field widths, codes,
// payload and command/status structs, and the size-to-class helper functions.
// No dependencies.
package scfla_pkg;

    localparam int SIZE_CLASSES   = 32;
    localparam int CLASS_STEP     = 8;
    localparam int OFFSET_BITS    = 16;
    localparam int SIZE_BITS      = 12;
    localparam int PAD_BITS       = 5;
    localparam int STATUS_BITS    = 2;
    localparam int KIND_BITS      = 2;
    localparam int SMALL_LIMIT    = 9;
    localparam int CLASS_BIAS     = 2;
    localparam int STORE_START_RESET = 264;

    localparam int CLASS_BITS     = $clog2(SIZE_CLASSES);
    localparam int STEP_SHIFT     = $clog2(CLASS_STEP);
    localparam int CLASS_RAW_BITS = SIZE_BITS + 1 - STEP_SHIFT;
    localparam int SLOT_BITS      = CLASS_BITS + 1 + STEP_SHIFT;
    localparam int LINK_BITS      = OFFSET_BITS - STEP_SHIFT;
    localparam int LINK_DEPTH     = 1 << LINK_BITS;

    localparam logic [OFFSET_BITS:0] SPACE_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_RESIZE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK      = 2'd0,
        STAT_TOO_BIG = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_TAKE,
        S_POP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] slot_offset;
        logic [SIZE_BITS-1:0]   new_size;
        logic [SIZE_BITS-1:0]   old_size;
    } req_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] result_offset;
        logic [CLASS_BITS-1:0]  size_class;
        logic [PAD_BITS-1:0]    padding_bytes;
        logic                   moved;
        logic [STATUS_BITS-1:0] status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;    // capture the accepted request
        logic    sel_old;    // head read port indexes the old class
        logic    cap_head;   // keep the new class's head
        logic    set_status;
        status_t status;
        logic    push;       // link the slot onto the old class list
        logic    bump;       // take the slot at the end pointer
        logic    link_rd;    // read the link of the kept head
        logic    pop;        // new head from the link, result from old head
        logic    out_load;   // move the finished result to the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic too_big;
        logic same_class;
        logic can_take;
        logic head_nz;
        logic out_free;
    } stat_t;

    // Raw class index; values at or above SIZE_CLASSES mean too big.
    function automatic logic [CLASS_RAW_BITS-1:0] class_of(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS:0]        up;
        logic [CLASS_RAW_BITS-1:0] q;
        up = {1'b0, size} + (SIZE_BITS+1)'(CLASS_STEP - 1);
        q  = up[SIZE_BITS:STEP_SHIFT];
        if (size < SIZE_BITS'(SMALL_LIMIT))
            return '0;
        else
            return q - CLASS_RAW_BITS'(CLASS_BIAS);
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_bytes(input logic [CLASS_BITS-1:0] cls);
        logic [CLASS_BITS:0] biased;
        biased = {1'b0, cls} + (CLASS_BITS+1)'(CLASS_BIAS);
        return {biased, {STEP_SHIFT{1'b0}}};
    endfunction

endpackage

/* rtl/scfla_datapath.sv */
// Datapath of the size-class free-list allocator: request registers, list
// heads, link memory, end pointer and the output register.
// Depends on scfla_pkg.
module scfla_datapath import scfla_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [OFFSET_BITS-1:0] cfg_data,
    input  req_t                   req,
    input  logic                   rsp_stall,
    output logic                   rsp_valid,
    output rsp_t                   rsp,
    input  cmd_t                   cmd,
    output stat_t                  stat
);

    logic [KIND_BITS-1:0]   kind_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [CLASS_BITS-1:0]  nc_reg;
    logic [CLASS_BITS-1:0]  oc_reg;
    logic                   n_big_reg;
    logic                   o_big_reg;
    logic [PAD_BITS-1:0]    npad_reg;
    logic [PAD_BITS-1:0]    opad_reg;
    logic [OFFSET_BITS-1:0] head_reg;
    logic [OFFSET_BITS-1:0] taken_reg;
    status_t                status_reg;
    logic [OFFSET_BITS-1:0] link_rdata_reg;
    logic [OFFSET_BITS:0]   store_end_reg;
    logic [OFFSET_BITS-1:0] heads_reg [SIZE_CLASSES];
    logic [OFFSET_BITS-1:0] link_mem [LINK_DEPTH];
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic [CLASS_RAW_BITS-1:0] n_raw;
    logic [CLASS_RAW_BITS-1:0] o_raw;
    logic [CLASS_BITS-1:0]     head_idx;
    logic [OFFSET_BITS-1:0]    head_rd;
    logic [OFFSET_BITS:0]      bump_end;
    logic                      off_nz;
    logic                      kind_bad;
    logic                      zero_all;
    rsp_t                      rsp_next;

    // Request decode at acceptance: classes, range checks and padding.
    assign n_raw = class_of(req.new_size);
    assign o_raw = class_of(req.old_size);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg  <= req.kind;
            off_reg   <= {req.slot_offset[OFFSET_BITS-1:STEP_SHIFT], {STEP_SHIFT{1'b0}}};
            nc_reg    <= n_raw[CLASS_BITS-1:0];
            oc_reg    <= o_raw[CLASS_BITS-1:0];
            n_big_reg <= (n_raw >= CLASS_RAW_BITS'(SIZE_CLASSES));
            o_big_reg <= (o_raw >= CLASS_RAW_BITS'(SIZE_CLASSES));
            npad_reg  <= PAD_BITS'(SIZE_BITS'(slot_bytes(n_raw[CLASS_BITS-1:0])) - req.new_size);
            opad_reg  <= PAD_BITS'(SIZE_BITS'(slot_bytes(o_raw[CLASS_BITS-1:0])) - req.old_size);
        end
        if (cmd.cap_head)
            head_reg <= head_rd;
        if (cmd.set_status)
            status_reg <= cmd.status;
        if (cmd.bump)
            taken_reg <= store_end_reg[OFFSET_BITS-1:0];
        else if (cmd.pop)
            taken_reg <= head_reg;
    end

    // One read port on the list heads, indexed by the new or the old class.
    assign head_idx = cmd.sel_old ? oc_reg : nc_reg;
    assign head_rd  = heads_reg[head_idx];
    assign off_nz   = (off_reg != '0);
    assign bump_end = store_end_reg + (OFFSET_BITS+1)'(slot_bytes(nc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIZE_CLASSES; i++)
                heads_reg[i] <= '0;
            store_end_reg <= (OFFSET_BITS+1)'(STORE_START_RESET) & ~(OFFSET_BITS+1)'(CLASS_STEP - 1);
        end
        else
        begin
            // Offset zero marks an empty list, so it is never pushed.
            if (cmd.push && off_nz)
                heads_reg[oc_reg] <= off_reg;
            else if (cmd.pop)
                heads_reg[nc_reg] <= link_rdata_reg;
            if (cfg_write)
                store_end_reg <= {1'b0, cfg_data[OFFSET_BITS-1:STEP_SHIFT], {STEP_SHIFT{1'b0}}};
            else if (cmd.bump)
                store_end_reg <= bump_end;
        end
    end

    // Link memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push && off_nz)
            link_mem[off_reg[OFFSET_BITS-1:STEP_SHIFT]] <= head_rd;
        if (cmd.link_rd)
            link_rdata_reg <= link_mem[head_reg[OFFSET_BITS-1:STEP_SHIFT]];
    end

    // Status for the controller.
    always_comb
    begin
        stat.kind       = kind_reg;
        stat.same_class = (nc_reg == oc_reg);
        stat.can_take   = (head_rd != '0) || (bump_end <= SPACE_LIMIT);
        stat.head_nz    = (head_reg != '0);
        stat.out_free   = !rsp_valid_reg || !rsp_stall;
        unique case (kind_reg)
            KIND_ALLOC:  stat.too_big = n_big_reg;
            KIND_FREE:   stat.too_big = o_big_reg;
            KIND_RESIZE: stat.too_big = n_big_reg || o_big_reg;
            default:     stat.too_big = 1'b0;
        endcase
    end

    // Result assembly from the request and the recorded outcome.
    always_comb
    begin
        kind_bad = (kind_reg != KIND_ALLOC) && (kind_reg != KIND_FREE)
                   && (kind_reg != KIND_RESIZE);
        zero_all = kind_bad || (status_reg == STAT_TOO_BIG);
        rsp_next.status = kind_bad ? STAT_OK : status_reg;
        rsp_next.moved  = (kind_reg == KIND_RESIZE) && (status_reg == STAT_OK)
                          && (nc_reg != oc_reg);
        if (zero_all)
        begin
            rsp_next.size_class    = '0;
            rsp_next.padding_bytes = '0;
        end
        else if (kind_reg == KIND_FREE)
        begin
            rsp_next.size_class    = oc_reg;
            rsp_next.padding_bytes = opad_reg;
        end
        else
        begin
            rsp_next.size_class    = nc_reg;
            rsp_next.padding_bytes = npad_reg;
        end
        if (zero_all || (status_reg != STAT_OK))
            rsp_next.result_offset = '0;
        else if ((kind_reg == KIND_FREE) || ((kind_reg == KIND_RESIZE) && (nc_reg == oc_reg)))
            rsp_next.result_offset = off_reg;
        else
            rsp_next.result_offset = taken_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/scfla_ctrl.sv */
// Controller of the size-class free-list allocator: sequences evaluate,
// push, take, pop and finish steps. Depends on scfla_pkg.
module scfla_ctrl import scfla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = S_EVAL;
            S_EVAL:
            begin
                unique case (stat.kind)
                    KIND_ALLOC:
                        state_next = (stat.too_big || !stat.can_take) ? S_FINISH : S_TAKE;
                    KIND_FREE:
                        state_next = stat.too_big ? S_FINISH : S_PUSH;
                    KIND_RESIZE:
                        state_next = (stat.too_big || stat.same_class || !stat.can_take)
                                     ? S_FINISH : S_PUSH;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_PUSH:
                state_next = (stat.kind == KIND_FREE) ? S_FINISH : S_TAKE;
            S_TAKE:
                state_next = stat.head_nz ? S_POP : S_FINISH;
            S_POP:
                state_next = S_FINISH;
            S_FINISH:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = STAT_OK;
        req_stall  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
                cmd.load_in = req_valid;
            S_EVAL:
            begin
                cmd.set_status = 1'b1;
                cmd.cap_head   = 1'b1;
                if (stat.too_big)
                    cmd.status = STAT_TOO_BIG;
                else if (((stat.kind == KIND_ALLOC)
                          || ((stat.kind == KIND_RESIZE) && !stat.same_class))
                         && !stat.can_take)
                    cmd.status = STAT_FULL;
                else
                    cmd.status = STAT_OK;
            end
            S_PUSH:
            begin
                cmd.sel_old = 1'b1;
                cmd.push    = 1'b1;
            end
            S_TAKE:
            begin
                cmd.link_rd = stat.head_nz;
                cmd.bump    = !stat.head_nz;
            end
            S_POP:
                cmd.pop = 1'b1;
            S_FINISH:
                cmd.out_load = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

/* rtl/size_class_free_list_allocator.sv */
// Top level of the size-class free-list allocator: joins the controller
// and the datapath. Depends on scfla_pkg, scfla_ctrl and scfla_datapath.
//
// Usage: a request transfer (req_valid high, req_stall low) carries kind,
// slot offset and the new and old byte sizes. Allocate pops the head of the
// size class's free list, or bumps the end pointer when that list is empty;
// free pushes the slot onto its class list; resize keeps the slot when the
// class is unchanged, else, if not full, frees it and allocates a new one.
// Every request yields exactly one result transfer on rsp (rsp_valid high,
// rsp_stall low) with offset, class, padding, a moved flag and status.
// Timing: one request is worked on at a time. After acceptance it is
// evaluated; a free or a changing resize pushes the slot, an allocate or a
// changing resize then bumps the end pointer or reads the head's link and
// pops, and the result enters the output register; the next request is
// accepted in the cycle after. The link memory holds one access per cycle,
// so a pop first reads the link in the take step once the head is known.
// The output register lets a new request be accepted while a result waits.
// If the receiver stalls, the result holds, and the following result waits
// in its final step until the output register frees up.
// Reset clears all list heads to empty and loads the end pointer from the
// store start reset value; no clearing pass is needed. cfg_write sets store
// start, reloads the end pointer; users write only while idle (unchecked).
module size_class_free_list_allocator import scfla_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [OFFSET_BITS-1:0] cfg_data,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp
);

    cmd_t  cmd;
    stat_t stat;

    // The controller only steers; all storage lives in the datapath.
    scfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    scfla_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
